@@ rtl/core/met_pkg.sv @@
// Shared types, constants and helpers of the escape-time unit.
`timescale 1ns / 1ps

package met_pkg;

  localparam int unsigned WORD_BITS     = 32;
  localparam int unsigned COORD_BITS    = 14;
  localparam int unsigned ITER_BITS     = 12;
  localparam int unsigned FRAC_BITS     = 28;
  localparam int unsigned STEP_BITS     = WORD_BITS - 1;
  localparam int unsigned PROD_BITS     = 2 * WORD_BITS;
  localparam int unsigned OFFS_BITS     = (STEP_BITS + 1) + (COORD_BITS + 1);
  localparam int unsigned ESC_EXP       = 2 * FRAC_BITS + 2;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = WORD_BITS;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_BITS     = $clog2(QUEUE_DEPTH);

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic [STEP_BITS-1:0]        step_t;
  typedef logic [COORD_BITS-1:0]       coord_t;
  typedef logic [ITER_BITS-1:0]        iter_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CENTER_RE  = 3'd0,
    REG_CENTER_IM  = 3'd1,
    REG_STEP_RE    = 3'd2,
    REG_STEP_IM    = 3'd3,
    REG_CENTER_COL = 3'd4,
    REG_CENTER_ROW = 3'd5,
    REG_MAX_ITER   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    word_t  center_re;
    word_t  center_im;
    step_t  step_re;
    step_t  step_im;
    coord_t center_col;
    coord_t center_row;
    iter_t  max_iter;
  } cfg_t;

  typedef struct packed {
    word_t re;
    word_t im;
  } point_t;

  typedef struct packed {
    iter_t iterations;
    logic  escaped;
    word_t final_re;
    word_t final_im;
  } result_t;

  localparam word_t  RST_CENTER_RE  = '0;
  localparam word_t  RST_CENTER_IM  = '0;
  localparam step_t  RST_STEP_RE    = step_t'(104858);
  localparam step_t  RST_STEP_IM    = step_t'(104858);
  localparam coord_t RST_CENTER_COL = coord_t'(5120);
  localparam coord_t RST_CENTER_ROW = coord_t'(5120);
  localparam iter_t  RST_MAX_ITER   = iter_t'(400);

  localparam prod_t SAT_HI = {{(PROD_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam prod_t SAT_LO = {{(PROD_BITS-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

  // Clamps a wide signed value to the signed word range.
  function automatic word_t sat_word(input prod_t v);
    word_t r;
    if (v > SAT_HI) begin
      r = {1'b0, {(WORD_BITS-1){1'b1}}};
    end else if (v < SAT_LO) begin
      r = {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      r = signed'(v[WORD_BITS-1:0]);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/met_channels_if.sv @@
// Handshake channel interfaces of the escape-time unit.
`timescale 1ns / 1ps

interface met_pix_if;
  logic             valid;
  logic             ready;
  met_pkg::coord_t  col;
  met_pkg::coord_t  row;
  modport source (output valid, output col, output row, input ready);
  modport sink   (input valid, input col, input row, output ready);
endinterface

interface met_res_if;
  logic            valid;
  logic            ready;
  met_pkg::iter_t  iterations;
  logic            escaped;
  met_pkg::word_t  final_re;
  met_pkg::word_t  final_im;
  modport source (output valid, output iterations, output escaped, output final_re,
                  output final_im, input ready);
  modport sink   (input valid, input iterations, input escaped, input final_re,
                  input final_im, output ready);
endinterface

interface met_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [met_pkg::CFG_IDX_BITS-1:0]    idx;
  logic [met_pkg::CFG_DATA_BITS-1:0]   data;
  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

@@ rtl/core/met_front.sv @@
// Front end: maps a pixel to its point c; the step product is registered and the saturated point is combinational.
`timescale 1ns / 1ps

module met_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  met_pkg::coord_t  col_i,
  input  met_pkg::coord_t  row_i,
  input  met_pkg::cfg_t    cfg_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output met_pkg::point_t  point_o
);

  logic signed [met_pkg::COORD_BITS:0]  dcol, drow;
  logic signed [met_pkg::STEP_BITS:0]   step_re_s, step_im_s;
  logic signed [met_pkg::OFFS_BITS-1:0] offs_re_d, offs_re_q, offs_im_d, offs_im_q;
  logic                                 offs_valid_q, offs_valid_d;
  logic                                 accept;

  assign dcol      = signed'({1'b0, col_i}) - signed'({1'b0, cfg_i.center_col});
  assign drow      = signed'({1'b0, row_i}) - signed'({1'b0, cfg_i.center_row});
  assign step_re_s = signed'({1'b0, cfg_i.step_re});
  assign step_im_s = signed'({1'b0, cfg_i.step_im});
  assign offs_re_d = step_re_s * dcol;
  assign offs_im_d = step_im_s * drow;

  assign in_ready_o = !offs_valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    offs_valid_d = offs_valid_q;
    if (accept) begin
      offs_valid_d = 1'b1;
    end else if (push_ready_i) begin
      offs_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offs_valid_q <= 1'b0;
    end else begin
      offs_valid_q <= offs_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      offs_re_q <= offs_re_d;
      offs_im_q <= offs_im_d;
    end
  end

  assign push_valid_o = offs_valid_q;
  assign point_o.re   = met_pkg::sat_word(met_pkg::prod_t'(cfg_i.center_re)
                                          - met_pkg::prod_t'(offs_re_q));
  assign point_o.im   = met_pkg::sat_word(met_pkg::prod_t'(cfg_i.center_im)
                                          - met_pkg::prod_t'(offs_im_q));

endmodule

@@ rtl/core/met_queue.sv @@
// Short point queue that decouples the front end from the iteration engine.
`timescale 1ns / 1ps

module met_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  met_pkg::point_t  push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output met_pkg::point_t  pop_data_o
);

  met_pkg::point_t                 mem_q [met_pkg::QUEUE_DEPTH];
  logic [met_pkg::QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
  logic [met_pkg::QPTR_BITS:0]     count_q;
  logic                            do_push, do_pop;

  assign push_ready_o = count_q != (met_pkg::QPTR_BITS+1)'(met_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  function automatic logic [met_pkg::QPTR_BITS-1:0] wrap_inc(
    input logic [met_pkg::QPTR_BITS-1:0] p
  );
    logic [met_pkg::QPTR_BITS-1:0] r;
    if (p == met_pkg::QPTR_BITS'(met_pkg::QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + met_pkg::QPTR_BITS'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wrap_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= wrap_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (met_pkg::QPTR_BITS+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (met_pkg::QPTR_BITS+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/core/met_iter.sv @@
// Iteration engine: runs z = z*z + c for one point and holds the result.
`timescale 1ns / 1ps

module met_iter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  met_pkg::iter_t   max_iter_i,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  met_pkg::point_t  pop_data_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output met_pkg::result_t res_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_DONE = 4'b1000
  } iter_state_e;

  localparam logic [met_pkg::PROD_BITS-1:0] ESC_LIMIT =
    met_pkg::PROD_BITS'(1) << met_pkg::ESC_EXP;

  iter_state_e      state_q, state_d;
  met_pkg::word_t   cre_q, cim_q, zre_q, zim_q, nre, nim;
  met_pkg::prod_t   rr_q, ii_q, ri_q, diff;
  met_pkg::iter_t   it_q, it_next;
  logic             esc_q;
  logic [met_pkg::PROD_BITS-1:0] mag;
  logic             escape;
  logic             slot_free;
  met_pkg::result_t res_q;
  logic             res_valid_q, res_valid_d;

  assign mag       = rr_q + ii_q;
  assign escape    = mag >= ESC_LIMIT;
  assign diff      = rr_q - ii_q;
  assign nre       = met_pkg::sat_word((diff >>> met_pkg::FRAC_BITS)
                                       + met_pkg::prod_t'(cre_q));
  assign nim       = met_pkg::sat_word((ri_q >>> (met_pkg::FRAC_BITS - 1))
                                       + met_pkg::prod_t'(cim_q));
  assign it_next   = it_q + met_pkg::iter_t'(1);
  assign slot_free = !res_valid_q || res_ready_i;

  assign pop_ready_o = state_q == ST_IDLE;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          state_d = (max_iter_i == '0) ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (escape || it_next == max_iter_i) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (state_q == ST_DONE && slot_free) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          cre_q <= pop_data_i.re;
          cim_q <= pop_data_i.im;
          zre_q <= '0;
          zim_q <= '0;
          it_q  <= '0;
          esc_q <= 1'b0;
        end
      end
      ST_MUL: begin
        rr_q <= zre_q * zre_q;
        ii_q <= zim_q * zim_q;
        ri_q <= zre_q * zim_q;
      end
      ST_UPD: begin
        if (escape) begin
          esc_q <= 1'b1;
        end else begin
          zre_q <= nre;
          zim_q <= nim;
          it_q  <= it_next;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          res_q.iterations <= it_q;
          res_q.escaped    <= esc_q;
          res_q.final_re   <= zre_q;
          res_q.final_im   <= zim_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/core/mandelbrot_escape_time_unit.sv @@
// Top level of the escape-time unit: configuration registers and the three parts.
//
//   channel  direction  payload                                  completes when
//   pix_i    in         col, row                                 valid && ready
//   res_o    out        iterations, escaped, final_re, final_im  valid && ready
//   cfg_i    in         idx (register), data                     valid && ready
//
// The front end takes a pixel every cycle while the queue has room and registers
// the step product before it forms the point c. The iteration engine tests z in
// two steps (multiply, then compare and update) and takes a new point only once
// the last result has gone to the output register.
// Reset clears the control state and loads the documented register defaults.
// A result that is not taken holds the engine; the queue keeps the front going while it has room.
`timescale 1ns / 1ps

module mandelbrot_escape_time_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  met_pix_if.sink   pix_i,
  met_res_if.source res_o,
  met_cfg_if.sink   cfg_i
);

  met_pkg::cfg_t    cfg_q;
  met_pkg::point_t  front_point, queue_point;
  logic             front_valid, queue_ready;
  logic             queue_valid, iter_ready;
  met_pkg::result_t result;

  // Configuration is always taken; a write to an index beyond the list is dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_re  <= met_pkg::RST_CENTER_RE;
      cfg_q.center_im  <= met_pkg::RST_CENTER_IM;
      cfg_q.step_re    <= met_pkg::RST_STEP_RE;
      cfg_q.step_im    <= met_pkg::RST_STEP_IM;
      cfg_q.center_col <= met_pkg::RST_CENTER_COL;
      cfg_q.center_row <= met_pkg::RST_CENTER_ROW;
      cfg_q.max_iter   <= met_pkg::RST_MAX_ITER;
    end else if (cfg_i.valid) begin
      // Bits above a register's width are dropped.
      unique case (cfg_i.idx)
        met_pkg::REG_CENTER_RE:  cfg_q.center_re  <= signed'(cfg_i.data);
        met_pkg::REG_CENTER_IM:  cfg_q.center_im  <= signed'(cfg_i.data);
        met_pkg::REG_STEP_RE:    cfg_q.step_re    <= cfg_i.data[met_pkg::STEP_BITS-1:0];
        met_pkg::REG_STEP_IM:    cfg_q.step_im    <= cfg_i.data[met_pkg::STEP_BITS-1:0];
        met_pkg::REG_CENTER_COL: cfg_q.center_col <= cfg_i.data[met_pkg::COORD_BITS-1:0];
        met_pkg::REG_CENTER_ROW: cfg_q.center_row <= cfg_i.data[met_pkg::COORD_BITS-1:0];
        met_pkg::REG_MAX_ITER:   cfg_q.max_iter   <= cfg_i.data[met_pkg::ITER_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: pixel offset, step product, then the saturated point c.
  met_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (pix_i.valid),
    .in_ready_o   (pix_i.ready),
    .col_i        (pix_i.col),
    .row_i        (pix_i.row),
    .cfg_i        (cfg_q),
    .push_valid_o (front_valid),
    .push_ready_i (queue_ready),
    .point_o      (front_point)
  );

  // Points wait here while the engine is busy with an earlier item.
  met_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (queue_ready),
    .push_data_i  (front_point),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (iter_ready),
    .pop_data_o   (queue_point)
  );

  // Back end: the escape-time loop and the output register.
  met_iter u_iter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_iter_i  (cfg_q.max_iter),
    .pop_valid_i (queue_valid),
    .pop_ready_o (iter_ready),
    .pop_data_i  (queue_point),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_o       (result)
  );

  assign res_o.iterations = result.iterations;
  assign res_o.escaped    = result.escaped;
  assign res_o.final_re   = result.final_re;
  assign res_o.final_im   = result.final_im;

endmodule
